### src/tssw_pkg.sv
`default_nettype none

package tssw_pkg;

	// coordinate and slope formats
	localparam int COORD_BITS      = 16;
	localparam int COORD_FRAC_BITS = 4;
	localparam int SLOPE_FRAC_BITS = 16;
	localparam int SLOPE_BITS      = 32;

	// derived widths
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int NUM_BITS  = COORD_BITS + SLOPE_FRAC_BITS;
	localparam int CNT_BITS  = $clog2(NUM_BITS);
	localparam int SAT_W     = ((NUM_BITS > SLOPE_BITS) ? NUM_BITS : SLOPE_BITS) + 1;
	localparam int PROD_W    = SLOPE_BITS + DIFF_BITS;
	localparam int PSH_W     = PROD_W - SLOPE_FRAC_BITS;
	localparam int SUM_W     = PSH_W + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [SLOPE_BITS-1:0] slope_t;
	typedef logic [NUM_BITS-1:0]          quot_t;
	typedef logic [COORD_BITS-1:0]        rem_t;
	typedef logic [CNT_BITS-1:0]          cnt_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [PSH_W-1:0]      psh_t;
	typedef logic signed [SUM_W-1:0]      sum_t;

	// opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_UPPER = 2'd1,
		PH_LOWER = 2'd2
	} phase_t;

	typedef enum logic {
		DST_LONG,
		DST_SHORT
	} div_dst_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT,
		ST_LONG,
		ST_DIV,
		ST_DIV_END,
		ST_MUL_R,
		ST_EDGE_R,
		ST_MUL_L,
		ST_EDGE_L,
		ST_ADV,
		ST_EMIT
	} state_t;

	// one whole row in coordinate units
	localparam diff_t ROW_STEP = diff_t'(1 << COORD_FRAC_BITS);

	// slope saturation limits
	localparam logic [SAT_W-1:0] SLOPE_POS_MAG =
		{{(SAT_W-SLOPE_BITS+1){1'b0}}, {(SLOPE_BITS-1){1'b1}}};
	localparam logic [SAT_W-1:0] SLOPE_NEG_MAG =
		{{(SAT_W-SLOPE_BITS){1'b0}}, 1'b1, {(SLOPE_BITS-1){1'b0}}};
	localparam slope_t SLOPE_MAX = {1'b0, {(SLOPE_BITS-1){1'b1}}};
	localparam slope_t SLOPE_MIN = {1'b1, {(SLOPE_BITS-1){1'b0}}};

	// edge x saturation limits
	localparam sum_t X_MAX = {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam sum_t X_MIN = {{(SUM_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

	// sign and saturate an unsigned quotient into a slope
	function automatic slope_t slope_sat(quot_t q, logic neg, logic dz);
		logic [SAT_W-1:0] qw;
		logic [SAT_W-1:0] qn;
		slope_t           r;
		qw = SAT_W'(q);
		qn = -qw;
		if (dz) begin
			r = '0;
		end else if (!neg) begin
			r = (qw > SLOPE_POS_MAG) ? SLOPE_MAX : qw[SLOPE_BITS-1:0];
		end else begin
			r = (qw > SLOPE_NEG_MAG) ? SLOPE_MIN : qn[SLOPE_BITS-1:0];
		end
		return r;
	endfunction

	// floor shift of the product, add start x, saturate
	function automatic coord_t edge_sat(prod_t p, coord_t x0);
		psh_t   ps;
		sum_t   s;
		coord_t r;
		ps = psh_t'(p >>> SLOPE_FRAC_BITS);
		s  = sum_t'(ps) + sum_t'(x0);
		if (s > X_MAX) begin
			r = X_MAX[COORD_BITS-1:0];
		end else if (s < X_MIN) begin
			r = X_MIN[COORD_BITS-1:0];
		end else begin
			r = s[COORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### src/triangle_scanline_span_walker.sv
`default_nettype none

// channel   direction  beat marked by            fields
// ------    ---------  ------------------------  ---------------------------------------
// command   in         start high, busy low      opcode, vert_{a,b,c}_{x,y}
// result    out        result_strobe, one cycle  span_valid, span_row, x_left,
//                                                x_right, last_span
//
// load: sort steps, a set-up state, then restoring divisions of 32 steps each
// on the one shared divider with a store state after each (the long slope, then
// a short one; the long slope only when all three y are equal); no result beat.
// step: two passes through the shared multiplier and saturating adder (right
// edge, then left edge), row advance, result beat; the divider forms the new
// short slope on the turn into the lower half. step with no walk: result beat only.
// asynchronous reset leaves no triangle loaded; no clearing pass.
// the receiver cannot stall: each result beat lasts exactly one cycle.

module triangle_scanline_span_walker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire logic            opcode,
	input  wire tssw_pkg::coord_t vert_a_x,
	input  wire tssw_pkg::coord_t vert_a_y,
	input  wire tssw_pkg::coord_t vert_b_x,
	input  wire tssw_pkg::coord_t vert_b_y,
	input  wire tssw_pkg::coord_t vert_c_x,
	input  wire tssw_pkg::coord_t vert_c_y,
	output logic                 result_strobe,
	output logic                 span_valid,
	output tssw_pkg::coord_t     span_row,
	output tssw_pkg::coord_t     x_left,
	output tssw_pkg::coord_t     x_right,
	output logic                 last_span
);
	import tssw_pkg::*;

	state_t   state_q, state_d;
	logic [1:0] sort_cnt_q;
	phase_t   phase_q;
	div_dst_t dst_q;
	logic     step_q;

	// sorted vertices: 0 min, 1 mid, 2 max
	coord_t vx0_q, vy0_q, vx1_q, vy1_q, vx2_q, vy2_q;
	slope_t long_slope_q, short_slope_q;
	coord_t row_q;

	// divider
	logic  div_neg_q, div_dz_q;
	quot_t div_num_q;
	rem_t  div_dvs_q, div_rem_q;
	cnt_t  div_cnt_q;

	// multiplier result
	prod_t prod_q;

	// result registers
	logic   span_valid_q, last_span_q;
	coord_t span_row_q, x_left_q, x_right_q;

	// combinational helpers
	logic   walk_on, top_flat, bot_flat, upper_more, lower_more;
	diff_t  next_row;
	logic   div_go;
	diff_t  div_dx, div_dy, div_mag;
	slope_t mul_a;
	diff_t  mul_b;
	coord_t short_x0;
	coord_t short_y0;
	slope_t div_slope;
	logic [COORD_BITS:0]   rem_shift;
	logic [COORD_BITS+1:0] trial;

	// walk conditions
	always_comb begin
		walk_on    = (phase_q == PH_UPPER) || (phase_q == PH_LOWER);
		top_flat   = (vy1_q == vy0_q);
		bot_flat   = (vy2_q == vy1_q);
		next_row   = diff_t'(row_q) + ROW_STEP;
		upper_more = next_row < diff_t'(vy1_q);
		lower_more = next_row < diff_t'(vy2_q);
		short_x0   = (phase_q == PH_UPPER) ? vx0_q : vx1_q;
		short_y0   = (phase_q == PH_UPPER) ? vy0_q : vy1_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (opcode == OP_LOAD) begin
						state_d = ST_SORT;
					end else begin
						state_d = walk_on ? ST_MUL_R : ST_EMIT;
					end
				end
			end
			ST_SORT: begin
				if (sort_cnt_q == 2'd2) begin
					state_d = ST_LONG;
				end
			end
			ST_LONG:   state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = ST_DIV_END;
				end
			end
			ST_DIV_END: begin
				if (dst_q == DST_LONG) begin
					state_d = div_go ? ST_DIV : ST_IDLE;
				end else begin
					state_d = step_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_MUL_R:  state_d = ST_EDGE_R;
			ST_EDGE_R: state_d = ST_MUL_L;
			ST_MUL_L:  state_d = ST_EDGE_L;
			ST_EDGE_L: state_d = ST_ADV;
			ST_ADV:    state_d = div_go ? ST_DIV : ST_EMIT;
			ST_EMIT:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs and unit operand selection
	always_comb begin
		busy          = (state_q != ST_IDLE);
		result_strobe = (state_q == ST_EMIT);
		div_go        = 1'b0;
		div_dx        = '0;
		div_dy        = '0;
		mul_a         = long_slope_q;
		mul_b         = diff_t'(row_q) - diff_t'(vy0_q);
		unique case (state_q)
			ST_LONG: begin
				div_go = 1'b1;
				div_dx = diff_t'(vx2_q) - diff_t'(vx0_q);
				div_dy = diff_t'(vy2_q) - diff_t'(vy0_q);
			end
			ST_DIV_END: begin
				if (dst_q == DST_LONG) begin
					if (!top_flat) begin
						div_go = 1'b1;
						div_dx = diff_t'(vx1_q) - diff_t'(vx0_q);
						div_dy = diff_t'(vy1_q) - diff_t'(vy0_q);
					end else if (!bot_flat) begin
						div_go = 1'b1;
						div_dx = diff_t'(vx2_q) - diff_t'(vx1_q);
						div_dy = diff_t'(vy2_q) - diff_t'(vy1_q);
					end
				end
			end
			ST_MUL_L: begin
				mul_a = short_slope_q;
				mul_b = diff_t'(row_q) - diff_t'(short_y0);
			end
			ST_ADV: begin
				if (phase_q == PH_UPPER && !upper_more && !bot_flat) begin
					div_go = 1'b1;
					div_dx = diff_t'(vx2_q) - diff_t'(vx1_q);
					div_dy = diff_t'(vy2_q) - diff_t'(vy1_q);
				end
			end
			default: begin
			end
		endcase
		div_mag   = div_dx[DIFF_BITS-1] ? -div_dx : div_dx;
		div_slope = slope_sat(div_num_q, div_neg_q, div_dz_q);
		rem_shift = {div_rem_q, div_num_q[NUM_BITS-1]};
		trial     = {1'b0, rem_shift} - {2'b00, div_dvs_q};
	end

	// sequencer registers and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sort_cnt_q    <= '0;
			phase_q       <= PH_IDLE;
			dst_q         <= DST_LONG;
			step_q        <= 1'b0;
			vx0_q         <= '0;
			vy0_q         <= '0;
			vx1_q         <= '0;
			vy1_q         <= '0;
			vx2_q         <= '0;
			vy2_q         <= '0;
			long_slope_q  <= '0;
			short_slope_q <= '0;
			row_q         <= '0;
			div_neg_q     <= 1'b0;
			div_dz_q      <= 1'b0;
			div_num_q     <= '0;
			div_dvs_q     <= '0;
			div_rem_q     <= '0;
			div_cnt_q     <= '0;
			prod_q        <= '0;
			span_valid_q  <= 1'b0;
			last_span_q   <= 1'b0;
			span_row_q    <= '0;
			x_left_q      <= '0;
			x_right_q     <= '0;
		end else begin
			state_q <= state_d;

			// launch a division on the shared divider
			if (div_go) begin
				dst_q     <= (state_q == ST_LONG) ? DST_LONG : DST_SHORT;
				div_neg_q <= div_dx[DIFF_BITS-1];
				div_dz_q  <= (div_dy == '0);
				div_num_q <= {div_mag[COORD_BITS-1:0], {SLOPE_FRAC_BITS{1'b0}}};
				div_dvs_q <= div_dy[COORD_BITS-1:0];
				div_rem_q <= '0;
				div_cnt_q <= cnt_t'(NUM_BITS - 1);
			end

			unique case (state_q)
				// command beat
				ST_IDLE: begin
					if (start) begin
						step_q <= opcode;
						if (opcode == OP_LOAD) begin
							vx0_q      <= vert_a_x;
							vy0_q      <= vert_a_y;
							vx1_q      <= vert_b_x;
							vy1_q      <= vert_b_y;
							vx2_q      <= vert_c_x;
							vy2_q      <= vert_c_y;
							sort_cnt_q <= '0;
						end else begin
							span_valid_q <= 1'b0;
							last_span_q  <= 1'b0;
							span_row_q   <= '0;
							x_left_q     <= '0;
							x_right_q    <= '0;
						end
					end
				end
				// stable compare and swap: pairs (0,1), (1,2), (0,1)
				ST_SORT: begin
					sort_cnt_q <= sort_cnt_q + 2'd1;
					if (sort_cnt_q == 2'd1) begin
						if (vy1_q > vy2_q) begin
							vx1_q <= vx2_q;
							vy1_q <= vy2_q;
							vx2_q <= vx1_q;
							vy2_q <= vy1_q;
						end
					end else begin
						if (vy0_q > vy1_q) begin
							vx0_q <= vx1_q;
							vy0_q <= vy1_q;
							vx1_q <= vx0_q;
							vy1_q <= vy0_q;
						end
					end
				end
				// one restoring step per cycle
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - cnt_t'(1);
					div_num_q <= {div_num_q[NUM_BITS-2:0], ~trial[COORD_BITS+1]};
					if (!trial[COORD_BITS+1]) begin
						div_rem_q <= trial[COORD_BITS-1:0];
					end else begin
						div_rem_q <= rem_shift[COORD_BITS-1:0];
					end
				end
				// store the slope, set up the walk after the long edge
				ST_DIV_END: begin
					if (dst_q == DST_LONG) begin
						long_slope_q <= div_slope;
						if (!top_flat) begin
							row_q   <= vy0_q;
							phase_q <= PH_UPPER;
						end else if (!bot_flat) begin
							row_q   <= vy1_q;
							phase_q <= PH_LOWER;
						end else begin
							short_slope_q <= '0;
							row_q         <= '0;
							phase_q       <= PH_IDLE;
						end
					end else begin
						short_slope_q <= div_slope;
					end
				end
				ST_MUL_R: begin
					prod_q       <= prod_t'(mul_a) * prod_t'(mul_b);
					span_valid_q <= 1'b1;
					last_span_q  <= 1'b0;
					span_row_q   <= row_q;
				end
				ST_EDGE_R: begin
					x_right_q <= edge_sat(prod_q, vx0_q);
				end
				ST_MUL_L: begin
					prod_q <= prod_t'(mul_a) * prod_t'(mul_b);
				end
				ST_EDGE_L: begin
					x_left_q <= edge_sat(prod_q, short_x0);
				end
				// advance the row or move to the next half
				ST_ADV: begin
					if (phase_q == PH_UPPER) begin
						if (upper_more) begin
							row_q <= next_row[COORD_BITS-1:0];
						end else if (!bot_flat) begin
							row_q   <= vy1_q;
							phase_q <= PH_LOWER;
						end else begin
							phase_q     <= PH_IDLE;
							last_span_q <= 1'b1;
						end
					end else begin
						if (lower_more) begin
							row_q <= next_row[COORD_BITS-1:0];
						end else begin
							phase_q     <= PH_IDLE;
							last_span_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign span_valid = span_valid_q;
	assign span_row   = span_row_q;
	assign x_left     = x_left_q;
	assign x_right    = x_right_q;
	assign last_span  = last_span_q;

`ifndef SYNTH
	// a result beat lasts one cycle and the block is idle after it
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe && !busy)
		else $error("result beat longer than one cycle");

	// a load never gives a result beat on the next cycle
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_LOAD) |=> !result_strobe)
		else $error("result beat after a load");

	// the final span is always a real span
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_span) |-> span_valid)
		else $error("last span without a span");

	// a done beat carries all zero fields
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !span_valid) |->
			(span_row == '0 && x_left == '0 && x_right == '0 && !last_span))
		else $error("done beat with non-zero fields");
`endif

endmodule

`default_nettype wire
